// ===== hw/rtl/ihex_pkg.sv =====
// Shared types, character codes and the hex digit decoder for the Intel HEX record decoder.
// No dependencies; the front, queue, back and top-level modules import this package.
`timescale 1ns / 1ps

package ihex_pkg;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  localparam logic [7:0] REC_DATA        = 8'h00;
  localparam logic [7:0] REC_EXT_SEGMENT = 8'h04;

  localparam logic [15:0] CONFIG_SEGMENT_RESET = 16'd48;
  localparam logic [9:0]  POS_MAX              = 10'd1023;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  // One queued command: either an error report or a data write.
  typedef struct packed {
    logic        error;
    logic        target;
    logic [15:0] base;
    logic [7:0]  index;
    logic [7:0]  data;
  } ihex_cmd_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.ok    = 1'b1;
    d.value = 4'd0;
    if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_0 + 8'd9) begin
      d.value = 4'(c - CHAR_DIGIT_0);
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_A + 8'd5) begin
      d.value = 4'(c - CHAR_UPPER_A + 8'd10);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_A + 8'd5) begin
      d.value = 4'(c - CHAR_LOWER_A + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/ihex_front.sv =====
// Character parser: tracks the line position and header fields, emits write and error commands.
// Depends on ihex_pkg.
`timescale 1ns / 1ps

module ihex_front import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        new_file,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  input  logic        space,
  output logic        push,
  output ihex_cmd_t   cmd
);

  logic [15:0] config_segment;
  logic [9:0]  char_position, char_position_next;
  logic [7:0]  record_length, record_length_next;
  logic [15:0] record_address, record_address_next;
  logic [7:0]  record_type, record_type_next;
  logic [15:0] segment_offset, segment_offset_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic        error_flag, error_flag_next;

  logic        accept;
  logic [9:0]  pos;
  logic [9:0]  pos_adv;
  logic [9:0]  data_limit;
  logic        is_field;
  hex_digit_t  digit;
  logic [15:0] addr_shift;

  assign in_ready = space;
  assign accept   = in_valid && space;
  assign digit    = hex_decode(in_char);

  always_comb begin
    char_position_next  = char_position;
    record_length_next  = record_length;
    record_address_next = record_address;
    record_type_next    = record_type;
    segment_offset_next = segment_offset;
    high_nibble_next    = high_nibble;
    error_flag_next     = error_flag;
    push                = 1'b0;
    cmd                 = '0;
    is_field            = 1'b0;

    if (new_file) begin
      segment_offset_next = '0;
      error_flag_next     = 1'b0;
      char_position_next  = '0;
      high_nibble_next    = '0;
    end

    // Position of this character in its line, after a possible new-file clear.
    pos        = char_position_next;
    pos_adv    = (pos == POS_MAX) ? pos : pos + 10'd1;
    data_limit = {1'b0, record_length, 1'b0} + 10'd9;
    addr_shift = {record_address[11:0], digit.value};

    if (pos <= 10'd8) begin
      is_field = 1'b1;
    end else if (record_type == REC_DATA) begin
      is_field = pos < data_limit;
    end else if (record_type == REC_EXT_SEGMENT) begin
      is_field = pos <= 10'd12;
    end

    if (!error_flag_next) begin
      if (pos == '0) begin
        if (in_char != CHAR_COLON) begin
          error_flag_next = 1'b1;
          push            = 1'b1;
          cmd.error       = 1'b1;
        end else begin
          record_length_next  = '0;
          record_address_next = '0;
          record_type_next    = '0;
          high_nibble_next    = '0;
          char_position_next  = 10'd1;
        end
      end else if (in_char == CHAR_NEWLINE) begin
        char_position_next = '0;
      end else if (!is_field) begin
        char_position_next = pos_adv;
      end else if (!digit.ok) begin
        error_flag_next = 1'b1;
        push            = 1'b1;
        cmd.error       = 1'b1;
      end else begin
        char_position_next = pos_adv;
        if (pos <= 10'd2) begin
          record_length_next = {record_length[3:0], digit.value};
        end else if (pos <= 10'd6) begin
          record_address_next = addr_shift;
        end else if (pos <= 10'd8) begin
          record_type_next = {record_type[3:0], digit.value};
        end else if (record_type == REC_EXT_SEGMENT) begin
          record_address_next = addr_shift;
          if (pos == 10'd12) begin
            segment_offset_next = addr_shift;
          end
        end else if (pos[0]) begin
          // Odd positions hold the first digit of a data byte.
          high_nibble_next = digit.value;
        end else begin
          cmd.base  = record_address;
          cmd.index = 8'(pos[9:1] - 9'd5);
          cmd.data  = {high_nibble, digit.value};
          if (segment_offset_next == '0) begin
            push       = 1'b1;
            cmd.target = 1'b0;
          end else if (segment_offset_next == config_segment) begin
            push       = 1'b1;
            cmd.target = 1'b1;
          end
        end
      end
    end

    if (!accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      config_segment <= CONFIG_SEGMENT_RESET;
      char_position  <= '0;
      record_length  <= '0;
      record_address <= '0;
      record_type    <= '0;
      segment_offset <= '0;
      high_nibble    <= '0;
      error_flag     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        config_segment <= cfg_data;
      end
      if (accept) begin
        char_position  <= char_position_next;
        record_length  <= record_length_next;
        record_address <= record_address_next;
        record_type    <= record_type_next;
        segment_offset <= segment_offset_next;
        high_nibble    <= high_nibble_next;
        error_flag     <= error_flag_next;
      end
    end
  end

endmodule

// ===== hw/rtl/ihex_queue.sv =====
// Short command queue between the parser and the result stage.
// Depends on ihex_pkg.
`timescale 1ns / 1ps

module ihex_queue import ihex_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ihex_cmd_t push_cmd,
  output logic      space,
  input  logic      pop,
  output logic      avail,
  output ihex_cmd_t head
);

  ihex_cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr;
  logic [QUEUE_PTR_W-1:0]   rd_ptr;
  logic [QUEUE_CNT_W-1:0]   count;
  logic                     do_pop;

  assign space  = count != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign avail  = count != '0;
  assign head   = entries[rd_ptr];
  assign do_pop = pop && avail;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ihex_back.sv =====
// Result stage: forms the final write address and holds the result in an output register.
// Depends on ihex_pkg.
`timescale 1ns / 1ps

module ihex_back import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        avail,
  input  ihex_cmd_t   head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        target,
  output logic [16:0] address,
  output logic [7:0]  data_byte,
  output logic        error
);

  assign pop = avail && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      target    <= head.target;
      address   <= {1'b0, head.base} + {9'd0, head.index};
      data_byte <= head.data;
      error     <= head.error;
    end
  end

endmodule

// ===== hw/rtl/intel_hex_record_decoder.sv =====
// Top level of the Intel HEX record decoder: parser front end, command queue, result stage.
// Depends on ihex_pkg, ihex_front, ihex_queue and ihex_back.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one ASCII character per transaction,
//   with new_file set on the first character of a new file to clear the segment offset,
//   the sticky error and the line position. Each completed data byte of a type 0 record
//   becomes one output transaction (target, address, data_byte) when the segment offset
//   is zero (program memory) or equals config_segment (configuration area). A malformed
//   line gives one output transaction with error set and everything else zero; after
//   that all characters are ignored until new_file is seen.
//   The configuration channel (cfg_valid/cfg_ready, cfg_data) writes config_segment;
//   it is always ready and should only be written while the decoder is idle.
//   Throughput is one character per clock while the command queue has space. The accepting
//   edge writes a result's command into the queue; the output register loads it from the
//   queue when the register is empty or its result is being taken.
//   When the receiver stalls, the two-entry queue and the output register absorb
//   results; in_ready drops only when the queue is full.
//   Reset (rst, synchronous) empties the queue and output register, clears the
//   parser state and loads config_segment with 48.
`timescale 1ns / 1ps

module intel_hex_record_decoder import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        new_file,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        target,
  output logic [16:0] address,
  output logic [7:0]  data_byte,
  output logic        error
);

  // Parser to queue.
  logic      push;
  ihex_cmd_t push_cmd;
  logic      space;

  // Queue to result stage.
  logic      pop;
  logic      avail;
  ihex_cmd_t head;

  // The configuration register takes a write on any cycle.
  assign cfg_ready = 1'b1;

  ihex_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .new_file  (new_file),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .space     (space),
    .push      (push),
    .cmd       (push_cmd)
  );

  ihex_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .space    (space),
    .pop      (pop),
    .avail    (avail),
    .head     (head)
  );

  // The result stage adds the byte index to the record address and drives the outputs.
  ihex_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (avail),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .target    (target),
    .address   (address),
    .data_byte (data_byte),
    .error     (error)
  );

endmodule

// ===== bench/intel_hex_record_decoder_checker.sv =====
// Checker for the Intel HEX record decoder: follows the parser state from the accepted
// characters and compares every output transaction with the predicted write or error report.
// Depends on ihex_pkg for character codes, record types and reset constants.
`timescale 1ns / 1ps

module intel_hex_record_decoder_checker import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        new_file,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        target,
  input  logic [16:0] address,
  input  logic [7:0]  data_byte,
  input  logic        error,
  output int          mismatch_count,
  output int          pending_count,
  output int          results_checked,
  output int          error_reports
);

  localparam int PRINT_LIMIT = 30;

  typedef struct packed {
    logic        tgt;
    logic [16:0] addr;
    logic [7:0]  data;
    logic        err;
  } ihex_write_t;

  ihex_write_t predicted_writes[$];
  ihex_write_t head;

  logic [15:0] cfg_segment;
  logic [9:0]  line_pos;
  logic [7:0]  rec_len;
  logic [15:0] rec_addr;
  logic [7:0]  rec_type;
  logic [15:0] seg_offset;
  logic [3:0]  hi_nibble;
  logic        sticky_err;

  int mismatches  = 0;
  int checked     = 0;
  int errors_seen = 0;

  // Bit 4 is set when the character is a hex digit of either case.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_0 + 8'd9) return {1'b1, 4'(c - CHAR_DIGIT_0)};
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_A + 8'd5) return {1'b1, 4'(c - CHAR_UPPER_A + 8'd10)};
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_A + 8'd5) return {1'b1, 4'(c - CHAR_LOWER_A + 8'd10)};
    return 5'd0;
  endfunction

  task automatic flag_malformed();
    predicted_writes.push_back('{tgt: 1'b0, addr: 17'd0, data: 8'd0, err: 1'b1});
    sticky_err = 1'b1;
  endtask

  task automatic advance_pos();
    if (line_pos < POS_MAX) line_pos = line_pos + 10'd1;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic nf);
    logic [4:0]  nib;
    logic        in_field;
    int          p;
    ihex_write_t w;
    if (nf) begin
      seg_offset = 16'd0;
      sticky_err = 1'b0;
      line_pos   = 10'd0;
      hi_nibble  = 4'd0;
    end
    if (sticky_err) return;
    if (line_pos == 10'd0) begin
      if (c != CHAR_COLON) begin
        flag_malformed();
        return;
      end
      rec_len   = 8'd0;
      rec_addr  = 16'd0;
      rec_type  = 8'd0;
      hi_nibble = 4'd0;
      line_pos  = 10'd1;
      return;
    end
    if (c == CHAR_NEWLINE) begin
      line_pos = 10'd0;
      return;
    end
    p = int'(line_pos);
    if (p <= 8) in_field = 1'b1;
    else if (rec_type == REC_DATA) in_field = (p < 9 + 2 * int'(rec_len));
    else if (rec_type == REC_EXT_SEGMENT) in_field = (p <= 12);
    else in_field = 1'b0;
    if (!in_field) begin
      advance_pos();
      return;
    end
    nib = nibble_of(c);
    if (!nib[4]) begin
      flag_malformed();
      return;
    end
    if (p <= 2) rec_len = {rec_len[3:0], nib[3:0]};
    else if (p <= 6) rec_addr = {rec_addr[11:0], nib[3:0]};
    else if (p <= 8) rec_type = {rec_type[3:0], nib[3:0]};
    else if (rec_type == REC_EXT_SEGMENT) begin
      rec_addr = {rec_addr[11:0], nib[3:0]};
      if (p == 12) seg_offset = rec_addr;
    end else if (((p - 9) % 2) == 0) begin
      hi_nibble = nib[3:0];
    end else begin
      advance_pos();
      if (seg_offset == 16'd0) w.tgt = 1'b0;
      else if (seg_offset == cfg_segment) w.tgt = 1'b1;
      else return;
      w.addr = {1'b0, rec_addr} + 17'((p - 10) / 2);
      w.data = {hi_nibble, nib[3:0]};
      w.err  = 1'b0;
      predicted_writes.push_back(w);
      return;
    end
    advance_pos();
  endtask

  task automatic check_field(input string name, input logic [16:0] exp_val,
                             input logic [16:0] act_val);
    if (act_val !== exp_val) begin
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_segment = CONFIG_SEGMENT_RESET;
      line_pos    = 10'd0;
      rec_len     = 8'd0;
      rec_addr    = 16'd0;
      rec_type    = 8'd0;
      seg_offset  = 16'd0;
      hi_nibble   = 4'd0;
      sticky_err  = 1'b0;
      predicted_writes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= PRINT_LIMIT)
            $display("%0t: unexpected result, expected none, got target %0d address %h data %h error %0d",
                     $time, target, address, data_byte, error);
        end else begin
          head = predicted_writes.pop_front();
          checked++;
          if (head.err) errors_seen++;
          check_field("target", 17'(head.tgt), 17'(target));
          check_field("address", head.addr, address);
          check_field("data_byte", 17'(head.data), 17'(data_byte));
          check_field("error", 17'(head.err), 17'(error));
        end
      end
      if (cfg_valid && cfg_ready) cfg_segment = cfg_data;
      if (in_valid && in_ready) decode_char(in_char, new_file);
    end
    mismatch_count  <= mismatches;
    pending_count   <= predicted_writes.size();
    results_checked <= checked;
    error_reports   <= errors_seen;
  end

endmodule

// ===== bench/intel_hex_record_decoder_test.sv =====
// Top of the Intel HEX record decoder bench: clock, reset, character stimulus and verdict.
// Depends on ihex_pkg, intel_hex_record_decoder and intel_hex_record_decoder_checker.
`timescale 1ns / 1ps

module intel_hex_record_decoder_test;
  import ihex_pkg::*;

  // Cycles without any transaction on any channel before the run is declared hung.
  localparam int STALL_LIMIT      = 2000;
  localparam int PHASES           = 6;
  localparam int CHARS_PER_PHASE  = 80;
  // Cycles waited after the last predicted result is taken, so that characters that
  // cause no result have also left the pipeline.
  localparam int DRAIN_CYCLES     = 4;
  // Ignored characters after a full-length data record, enough to run the position
  // counter past its top value.
  localparam int LONG_LINE_CHARS  = 520;
  localparam int MAX_RECORD_BYTES = 255;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_char   = 8'd0;
  logic        new_file  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data  = 16'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        cfg_ready;
  logic        out_valid;
  logic        target;
  logic [16:0] address;
  logic [7:0]  data_byte;
  logic        error;

  int mismatch_count;
  int pending_count;
  int results_checked;
  int error_reports;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int chars_sent    = 0;
  int quiet_cycles  = 0;

  // Set after a line that leaves the decoder in its sticky error state (or mid-line),
  // so that the next line starts a new file and parsing resumes.
  logic        restart_file = 1'b0;
  logic [15:0] config_value = CONFIG_SEGMENT_RESET;

  intel_hex_record_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .new_file  (new_file),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .target    (target),
    .address   (address),
    .data_byte (data_byte),
    .error     (error)
  );

  intel_hex_record_decoder_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char         (in_char),
    .new_file        (new_file),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .target          (target),
    .address         (address),
    .data_byte       (data_byte),
    .error           (error),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .error_reports   (error_reports)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver decides anew at every edge whether it takes a result in the next cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: any accepted transaction on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles at %0t", STALL_LIMIT, $time);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one character and hold it until the decoder takes it. Random idle cycles come
  // first; valid is only lowered in a step where it is not raised again.
  task automatic send_char(input logic [7:0] c, input logic nf);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    new_file <= nf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  // Letters come out in upper or lower case at random.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CHAR_DIGIT_0 + 8'(n);
    return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(n) - 8'd10;
  endfunction

  // Any byte except a newline, so it never ends the line.
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CHAR_NEWLINE);
    return c;
  endfunction

  // A byte that is neither a hex digit nor a newline.
  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CHAR_NEWLINE
           || (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_0 + 8'd9)
           || (c >= CHAR_UPPER_A && c <= CHAR_UPPER_A + 8'd5)
           || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_A + 8'd5));
    return c;
  endfunction

  task automatic send_hex(input logic [15:0] value, input int digits);
    for (int i = digits - 1; i >= 0; i--) send_char(hex_char(value[i*4 +: 4]), 1'b0);
  endtask

  // Checksum digits, then sometimes a carriage return or trailing garbage, then newline.
  task automatic finish_line();
    int n;
    send_hex(16'($urandom_range(255)), 2);
    if ($urandom_range(99) < 30) send_char(8'h0D, 1'b0);
    if ($urandom_range(99) < 10) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_char(junk_char(), 1'b0);
    end
    send_char(CHAR_NEWLINE, 1'b0);
  endtask

  // Stop offering characters and wait until every predicted result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The segment register is only changed while the decoder is idle.
  task automatic write_config(input logic [15:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    config_value = value;
  endtask

  // One line of hex text. Most lines are well-formed data or segment records so the
  // decoder reaches its write path; the rest are other record types, truncated lines,
  // spoiled digits, lines without a colon, and new-file restarts in mid-line.
  task automatic gen_line(input logic full_record);
    int          kind;
    int          r;
    int          n;
    int          cut;
    logic        nf;
    logic [7:0]  len;
    logic [15:0] addr;
    logic [15:0] offset;
    logic [7:0]  rtype;
    logic [7:0]  c;
    logic [3:0]  digits[$];
    nf = restart_file || ($urandom_range(99) < 3);
    restart_file = 1'b0;
    kind = full_record ? 0 : $urandom_range(99);
    if (kind < 55) begin
      // Data record: mostly short, sometimes long, now and then near the top of memory
      // so that the byte index carries into bit 16 of the address.
      r = $urandom_range(99);
      if (full_record || r < 2) len = 8'd255;
      else if (r < 8) len = 8'($urandom_range(17, 64));
      else len = 8'($urandom_range(0, 16));
      if (full_record) addr = 16'hFFFF;
      else if ($urandom_range(99) < 10) addr = 16'hFFFF - 16'($urandom_range(15));
      else addr = 16'($urandom);
      send_char(CHAR_COLON, nf);
      send_hex(16'(len), 2);
      send_hex(addr, 4);
      send_hex(16'(REC_DATA), 2);
      for (int i = 0; i < int'(len); i++) send_hex(16'($urandom_range(255)), 2);
      finish_line();
    end else if (kind < 73) begin
      // Segment record: zero, the configured segment, or anything else.
      r = $urandom_range(99);
      if (r < 35) offset = 16'd0;
      else if (r < 70) offset = config_value;
      else offset = 16'($urandom);
      len = ($urandom_range(99) < 80) ? 8'd2 : 8'($urandom_range(255));
      send_char(CHAR_COLON, nf);
      send_hex(16'(len), 2);
      send_hex(16'($urandom), 4);
      send_hex(16'(REC_EXT_SEGMENT), 2);
      send_hex(offset, 4);
      finish_line();
    end else if (kind < 80) begin
      // Any other record type: everything after the type field is ignored.
      do rtype = 8'($urandom_range(255));
      while (rtype == REC_DATA || rtype == REC_EXT_SEGMENT);
      send_char(CHAR_COLON, nf);
      send_hex(16'($urandom_range(255)), 2);
      send_hex(16'($urandom), 4);
      send_hex(16'(rtype), 2);
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) send_char(junk_char(), 1'b0);
      send_char(CHAR_NEWLINE, 1'b0);
    end else if (kind < 92) begin
      // Truncated line, or one with a non-hex character inside a decoded field.
      len   = 8'($urandom_range(1, 8));
      rtype = $urandom_range(1) ? REC_DATA : REC_EXT_SEGMENT;
      addr  = 16'($urandom);
      for (int i = 1; i >= 0; i--) digits.push_back(len[i*4 +: 4]);
      for (int i = 3; i >= 0; i--) digits.push_back(addr[i*4 +: 4]);
      for (int i = 1; i >= 0; i--) digits.push_back(rtype[i*4 +: 4]);
      n = (rtype == REC_DATA) ? 2 * int'(len) : 4;
      for (int i = 0; i < n; i++) digits.push_back(4'($urandom_range(15)));
      cut = $urandom_range(0, digits.size() - 1);
      send_char(CHAR_COLON, nf);
      for (int i = 0; i < cut; i++) send_char(hex_char(digits[i]), 1'b0);
      if (kind >= 86) begin
        send_char(bad_char(), 1'b0);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) send_char(junk_char(), 1'b0);
        restart_file = 1'b1;
      end
      send_char(CHAR_NEWLINE, 1'b0);
    end else if (kind < 96) begin
      // No colon at the start of the line; an empty line is one case of this.
      if ($urandom_range(99) < 30) c = CHAR_NEWLINE;
      else begin
        do c = junk_char();
        while (c == CHAR_COLON);
      end
      send_char(c, nf);
      if (c != CHAR_NEWLINE) begin
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) send_char(junk_char(), 1'b0);
        send_char(CHAR_NEWLINE, 1'b0);
      end
      restart_file = 1'b1;
    end else begin
      // Abandon the line in mid-header or just past it; the next line restarts the file.
      send_char(CHAR_COLON, nf);
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) send_char(hex_char(4'($urandom_range(15))), 1'b0);
      restart_file = 1'b1;
    end
  endtask

  // Keep generating lines until the character count of the phase is reached.
  task automatic n_phase_chars(input int phase_end);
    while (chars_sent < phase_end) gen_line(1'b0);
  endtask

  initial begin : stimulus
    logic [15:0] cfg_plan [PHASES];
    int          phase_end;
    cfg_plan = '{16'h0000, 16'hFFFF, 16'($urandom), CONFIG_SEGMENT_RESET,
                 16'($urandom), 16'h0001};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, under the reset value of the segment register. An empty line is
    // an error; a new file clears it and a one-byte record at the top address follows;
    // a segment record selects the configuration area; a bad length digit ends it all.
    send_char(CHAR_NEWLINE, 1'b1);
    send_char(CHAR_COLON, 1'b1);
    send_hex(16'h01, 2);
    send_hex(16'hFFFF, 4);
    send_hex(16'(REC_DATA), 2);
    send_char("a", 1'b0);
    send_char("B", 1'b0);
    send_char(8'h0D, 1'b0);
    send_char(CHAR_NEWLINE, 1'b0);
    send_char(CHAR_COLON, 1'b0);
    send_hex(16'h02, 2);
    send_hex(16'h0000, 4);
    send_hex(16'(REC_EXT_SEGMENT), 2);
    send_hex(CONFIG_SEGMENT_RESET, 4);
    send_char(CHAR_NEWLINE, 1'b0);
    send_char(CHAR_COLON, 1'b0);
    send_char("1", 1'b0);
    send_char("g", 1'b0);
    restart_file = 1'b1;

    // Random phases. Each one starts from an idle decoder with a new segment value and
    // one of four idling patterns on the two channels, taken in turn.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_config(cfg_plan[ph]);
      phase_end = chars_sent + CHARS_PER_PHASE;
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 71;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 71;
        end
        default: begin
          send_idle_pct = 8;
          stall_pct     = 8;
        end
      endcase
      if (ph == 2) begin
        // A record of the greatest length at the top address, so the byte index carries
        // into bit 16, then a tail longer than the position counter can count: it has to
        // saturate, not wrap to the start of a line, or the next colon would be misread.
        send_char(CHAR_COLON, 1'b1);
        send_hex(16'(MAX_RECORD_BYTES), 2);
        send_hex(16'hFFFF, 4);
        send_hex(16'(REC_DATA), 2);
        for (int i = 0; i < MAX_RECORD_BYTES; i++) send_hex(16'($urandom_range(255)), 2);
        for (int i = 0; i < LONG_LINE_CHARS; i++) send_char(junk_char(), 1'b0);
        send_char(CHAR_NEWLINE, 1'b0);
        restart_file = 1'b0;
      end
      n_phase_chars(phase_end);
    end

    wait_for_results();
    $display("Sent %0d characters: a directed part and %0d random phases with segment values",
             chars_sent, PHASES);
    $display("from 0 to ffff; %0d output transactions checked, %0d of them error reports.",
             results_checked, error_reports);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_front.sv
hw/rtl/ihex_queue.sv
hw/rtl/ihex_back.sv
hw/rtl/intel_hex_record_decoder.sv
bench/intel_hex_record_decoder_checker.sv
bench/intel_hex_record_decoder_test.sv
